/* design/rrf_pkg.sv */
// shared types and constants of the resp request framer
package rrf_pkg;

  localparam logic [7:0] CH_CR       = 8'h0D;
  localparam logic [7:0] CH_LF       = 8'h0A;
  localparam logic [7:0] MARK_SIMPLE = 8'h2B;
  localparam logic [7:0] MARK_BULK   = 8'h24;
  localparam logic [7:0] MARK_ARRAY  = 8'h2A;
  localparam logic [7:0] CH_DIGIT0   = 8'h30;
  localparam logic [7:0] CH_DIGIT9   = 8'h39;

  localparam logic [1:0] EV_BYTE     = 2'd0;
  localparam logic [1:0] EV_WORD_END = 2'd1;
  localparam logic [1:0] EV_CMD_END  = 2'd2;
  localparam logic [1:0] EV_ERROR    = 2'd3;

  localparam logic [1:0] CK_SIMPLE   = 2'd0;
  localparam logic [1:0] CK_BULK     = 2'd1;
  localparam logic [1:0] CK_ARRAY    = 2'd2;

  localparam int QDEPTH = 4;
  localparam int QAW    = 2;

  typedef struct packed {
    logic [1:0]  event_kind;
    logic [7:0]  payload;
    logic        word_first;
    logic [9:0]  word_number;
    logic [1:0]  command_kind;
    logic [15:0] command_bytes;
  } ev_t;

  // one queue entry holds the results of one byte
  typedef struct packed {
    logic two;
    ev_t  ev0;
    ev_t  ev1;
  } entry_t;

  typedef struct packed {
    logic   empty;
    entry_t head;
  } q_head_t;

endpackage

/* design/rrf_ifs.sv */
// byte input and event output channel interfaces
interface rrf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

interface rrf_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  event_kind;
  logic [7:0]  payload;
  logic        word_first;
  logic [9:0]  word_number;
  logic [1:0]  command_kind;
  logic [15:0] command_bytes;
  logic        last_result;

  modport source (output valid, output event_kind, output payload, output word_first,
                  output word_number, output command_kind, output command_bytes,
                  output last_result, input ready);
  modport sink (input valid, input event_kind, input payload, input word_first,
                input word_number, input command_kind, input command_bytes,
                input last_result, output ready);
endinterface

/* design/rrf_front.sv */
// front end: parses one byte per cycle while the queue is not full and builds the events it causes
module rrf_front #(
  parameter int MAX_ELEMENTS = 1024,
  parameter int COUNT_BITS   = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [7:0]        in_data,
  output logic              in_ready,
  input  logic              q_full,
  output logic              push,
  output rrf_pkg::entry_t   push_entry
);

  localparam int EC_W = $clog2(MAX_ELEMENTS + 1);
  localparam int LL_W = EC_W + 1;
  localparam int V_W  = EC_W + 4;
  localparam int CW   = COUNT_BITS;
  localparam logic [CW+15:0] SAT16 = (CW + 16)'(17'h0FFFF);
  localparam logic [V_W-1:0] MAX_V = V_W'(MAX_ELEMENTS);

  localparam logic [2:0] M_IDLE      = 3'd0;
  localparam logic [2:0] M_SIMPLE    = 3'd1;
  localparam logic [2:0] M_BULK_HDR  = 3'd2;
  localparam logic [2:0] M_BULK_DATA = 3'd3;
  localparam logic [2:0] M_CNT_EMPTY = 3'd4;
  localparam logic [2:0] M_CNT       = 3'd5;
  localparam logic [2:0] M_BODY      = 3'd6;

  logic [2:0]      mode_r, mode_nxt;
  logic            pend_r, pend_nxt;
  logic [EC_W-1:0] ec_r, ec_nxt;
  logic [LL_W-1:0] ll_r, ll_nxt;
  logic            liw_r, liw_nxt;
  logic            aws_r, aws_nxt;
  logic [9:0]      wc_r, wc_nxt;
  logic [CW-1:0]   bc_r, bc_nxt;
  logic [1:0]      kind_r, kind_nxt;

  logic [CW-1:0]   bc_inc;
  logic [CW+15:0]  bc_ext;
  logic [15:0]     bytes_sat;
  logic [V_W-1:0]  v;
  logic [LL_W-1:0] ll_dec;
  logic            accept;
  logic            is_word;
  logic            line_end;
  logic [1:0]      n;
  rrf_pkg::ev_t    ev0, ev1;

  function automatic rrf_pkg::ev_t mk_ev(input logic [1:0] kind, input logic [7:0] pay,
                                         input logic first, input logic [9:0] wn,
                                         input logic [1:0] ck, input logic [15:0] bytes);
    rrf_pkg::ev_t e;
    e.event_kind    = kind;
    e.payload       = pay;
    e.word_first    = first;
    e.word_number   = wn;
    e.command_kind  = ck;
    e.command_bytes = bytes;
    return e;
  endfunction

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    mode_nxt = mode_r;
    pend_nxt = pend_r;
    ec_nxt   = ec_r;
    ll_nxt   = ll_r;
    liw_nxt  = liw_r;
    aws_nxt  = aws_r;
    wc_nxt   = wc_r;
    bc_nxt   = bc_r;
    kind_nxt = kind_r;
    ev0      = '0;
    ev1      = '0;
    n        = 2'd0;
    is_word  = 1'b0;
    line_end = 1'b0;

    bc_inc    = (bc_r == {CW{1'b1}}) ? bc_r : bc_r + CW'(1);
    bc_ext    = {16'd0, bc_inc};
    bytes_sat = (bc_ext > SAT16) ? 16'hFFFF : bc_ext[15:0];
    v         = (V_W'(ec_r) << 3) + (V_W'(ec_r) << 1) + V_W'(in_data[3:0]);
    ll_dec    = (ll_r != '0) ? ll_r - LL_W'(1) : ll_r;

    if (accept) begin
      if (mode_r == M_IDLE) begin
        if (in_data inside {rrf_pkg::MARK_SIMPLE, rrf_pkg::MARK_BULK, rrf_pkg::MARK_ARRAY}) begin
          bc_nxt  = CW'(1);
          wc_nxt  = 10'd0;
          aws_nxt = 1'b1;
          pend_nxt = 1'b0;
          liw_nxt = 1'b0;
          ec_nxt  = '0;
          ll_nxt  = '0;
          case (in_data)
            rrf_pkg::MARK_SIMPLE: begin
              kind_nxt = rrf_pkg::CK_SIMPLE;
              mode_nxt = M_SIMPLE;
            end
            rrf_pkg::MARK_BULK: begin
              kind_nxt = rrf_pkg::CK_BULK;
              mode_nxt = M_BULK_HDR;
            end
            default: begin
              kind_nxt = rrf_pkg::CK_ARRAY;
              mode_nxt = M_CNT_EMPTY;
            end
          endcase
        end
      end else begin
        bc_nxt = bc_inc;
        case (mode_r)
          M_SIMPLE, M_BULK_DATA, M_BULK_HDR, M_BODY: begin
            is_word = (mode_r == M_SIMPLE) || (mode_r == M_BULK_DATA) ||
                      ((mode_r == M_BODY) && liw_r);
            if (pend_r) begin
              if (in_data == rrf_pkg::CH_LF) begin
                pend_nxt = 1'b0;
                line_end = 1'b1;
              end else begin
                // lone cr goes out as data, then the byte after it unless that is another cr
                if (is_word) begin
                  ev0 = mk_ev(rrf_pkg::EV_BYTE, rrf_pkg::CH_CR, aws_r, wc_r, kind_r, 16'd0);
                  n = 2'd1;
                  aws_nxt = 1'b0;
                end
                if (in_data != rrf_pkg::CH_CR) begin
                  pend_nxt = 1'b0;
                  if (is_word) begin
                    ev1 = mk_ev(rrf_pkg::EV_BYTE, in_data, 1'b0, wc_r, kind_r, 16'd0);
                    n = 2'd2;
                  end
                end
              end
            end else if (in_data == rrf_pkg::CH_CR) begin
              pend_nxt = 1'b1;
            end else if (is_word) begin
              ev0 = mk_ev(rrf_pkg::EV_BYTE, in_data, aws_r, wc_r, kind_r, 16'd0);
              n = 2'd1;
              aws_nxt = 1'b0;
            end

            if (line_end) begin
              if (mode_r == M_BULK_HDR) begin
                mode_nxt = M_BULK_DATA;
              end else if (mode_r == M_BODY) begin
                ll_nxt  = ll_dec;
                liw_nxt = !liw_r;
                if (liw_r) begin
                  ev0 = mk_ev(rrf_pkg::EV_WORD_END, 8'd0, 1'b0, wc_r, kind_r, 16'd0);
                  n = 2'd1;
                  wc_nxt = wc_r + 10'd1;
                  aws_nxt = 1'b1;
                end
                if (ll_dec == '0) begin
                  if (liw_r) begin
                    ev1 = mk_ev(rrf_pkg::EV_CMD_END, 8'd0, 1'b0, 10'd0, kind_r, bytes_sat);
                    n = 2'd2;
                  end else begin
                    ev0 = mk_ev(rrf_pkg::EV_CMD_END, 8'd0, 1'b0, 10'd0, kind_r, bytes_sat);
                    n = 2'd1;
                  end
                  mode_nxt = M_IDLE;
                  pend_nxt = 1'b0;
                end
              end else begin
                ev0 = mk_ev(rrf_pkg::EV_WORD_END, 8'd0, 1'b0, wc_r, kind_r, 16'd0);
                ev1 = mk_ev(rrf_pkg::EV_CMD_END, 8'd0, 1'b0, 10'd0, kind_r, bytes_sat);
                n = 2'd2;
                wc_nxt = wc_r + 10'd1;
                aws_nxt = 1'b1;
                mode_nxt = M_IDLE;
                pend_nxt = 1'b0;
              end
            end
          end
          M_CNT_EMPTY, M_CNT: begin
            if (pend_r) begin
              pend_nxt = 1'b0;
              if (in_data != rrf_pkg::CH_LF) begin
                ev0 = mk_ev(rrf_pkg::EV_ERROR, 8'd0, 1'b0, 10'd0, kind_r, 16'd0);
                n = 2'd1;
                mode_nxt = M_IDLE;
              end else begin
                ll_nxt  = {ec_r, 1'b0};
                liw_nxt = 1'b0;
                if (ec_r == '0) begin
                  ev0 = mk_ev(rrf_pkg::EV_CMD_END, 8'd0, 1'b0, 10'd0, kind_r, bytes_sat);
                  n = 2'd1;
                  mode_nxt = M_IDLE;
                end else begin
                  mode_nxt = M_BODY;
                end
              end
            end else if (in_data == rrf_pkg::CH_CR) begin
              if (mode_r == M_CNT_EMPTY) begin
                ev0 = mk_ev(rrf_pkg::EV_ERROR, 8'd0, 1'b0, 10'd0, kind_r, 16'd0);
                n = 2'd1;
                mode_nxt = M_IDLE;
              end else begin
                pend_nxt = 1'b1;
              end
            end else if (in_data inside {[rrf_pkg::CH_DIGIT0:rrf_pkg::CH_DIGIT9]}) begin
              if (v > MAX_V) begin
                ev0 = mk_ev(rrf_pkg::EV_ERROR, 8'd0, 1'b0, 10'd0, kind_r, 16'd0);
                n = 2'd1;
                mode_nxt = M_IDLE;
              end else begin
                ec_nxt   = v[EC_W-1:0];
                mode_nxt = M_CNT;
              end
            end else begin
              ev0 = mk_ev(rrf_pkg::EV_ERROR, 8'd0, 1'b0, 10'd0, kind_r, 16'd0);
              n = 2'd1;
              mode_nxt = M_IDLE;
            end
          end
          default: begin
            mode_nxt = M_IDLE;
            pend_nxt = 1'b0;
          end
        endcase
      end
    end
  end

  assign push           = accept && (n != 2'd0);
  assign push_entry.two = (n == 2'd2);
  assign push_entry.ev0 = ev0;
  assign push_entry.ev1 = ev1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_IDLE;
      pend_r <= 1'b0;
      ec_r   <= '0;
      ll_r   <= '0;
      liw_r  <= 1'b0;
      aws_r  <= 1'b1;
      wc_r   <= 10'd0;
      bc_r   <= '0;
      kind_r <= rrf_pkg::CK_SIMPLE;
    end else begin
      mode_r <= mode_nxt;
      pend_r <= pend_nxt;
      ec_r   <= ec_nxt;
      ll_r   <= ll_nxt;
      liw_r  <= liw_nxt;
      aws_r  <= aws_nxt;
      wc_r   <= wc_nxt;
      bc_r   <= bc_nxt;
      kind_r <= kind_nxt;
    end
  end

endmodule

/* design/rrf_queue.sv */
// small fifo of per-byte event entries between front and back
module rrf_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  rrf_pkg::entry_t   push_entry,
  input  logic              pop,
  output logic              full,
  output rrf_pkg::q_head_t  head
);

  rrf_pkg::entry_t              mem_r [rrf_pkg::QDEPTH];
  logic [rrf_pkg::QAW-1:0]      wp_r, wp_nxt;
  logic [rrf_pkg::QAW-1:0]      rp_r, rp_nxt;
  logic [rrf_pkg::QAW:0]        cnt_r, cnt_nxt;

  assign full       = (cnt_r == (rrf_pkg::QAW + 1)'(rrf_pkg::QDEPTH));
  assign head.empty = (cnt_r == '0);
  assign head.head  = mem_r[rp_r];

  always_comb begin
    wp_nxt  = push ? wp_r + 1'b1 : wp_r;
    rp_nxt  = pop ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r + (rrf_pkg::QAW + 1)'(push) - (rrf_pkg::QAW + 1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

/* design/rrf_back.sv */
// back end: sends the one or two events of each queue entry in order
module rrf_back (
  input  logic              clk,
  input  logic              rst_n,
  input  rrf_pkg::q_head_t  head,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output rrf_pkg::ev_t      out_ev,
  output logic              out_last
);

  logic sel_r, sel_nxt;
  logic fire;

  assign out_valid = !head.empty;
  assign out_ev    = sel_r ? head.head.ev1 : head.head.ev0;
  assign out_last  = !head.head.two || sel_r;
  assign fire      = out_valid && out_ready;
  assign pop       = fire && out_last;

  always_comb begin
    sel_nxt = sel_r;
    if (fire) begin
      sel_nxt = !out_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_r <= 1'b0;
    end else begin
      sel_r <= sel_nxt;
    end
  end

endmodule

/* design/resp_request_framer_top.sv */
// a byte's events are registered in the event queue and offered after any earlier entries
// throughput: one byte per cycle while the output is ready and no byte causes two events;
//   a two-event byte holds its entry until both go out; a 4-entry queue absorbs this
// input stalls only when the event queue is full
// reset: synchronous active-low, parser returns to idle and the queue empties
module resp_request_framer_top #(
  parameter int MAX_ELEMENTS = 1024,
  parameter int COUNT_BITS   = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  rrf_in_if.sink       in_ch,
  rrf_out_if.source    out_ch
);

  logic              q_full;
  logic              push;
  logic              pop;
  rrf_pkg::entry_t   push_entry;
  rrf_pkg::q_head_t  head;
  rrf_pkg::ev_t      out_ev;
  logic              out_last;
  logic              out_valid;
  logic              in_ready;

  rrf_front #(
    .MAX_ELEMENTS (MAX_ELEMENTS),
    .COUNT_BITS   (COUNT_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_data    (in_ch.data_byte),
    .in_ready   (in_ready),
    .q_full     (q_full),
    .push       (push),
    .push_entry (push_entry)
  );

  rrf_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .full       (q_full),
    .head       (head)
  );

  rrf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .out_ev    (out_ev),
    .out_last  (out_last)
  );

  assign in_ch.ready          = in_ready;
  assign out_ch.valid         = out_valid;
  assign out_ch.event_kind    = out_ev.event_kind;
  assign out_ch.payload       = out_ev.payload;
  assign out_ch.word_first    = out_ev.word_first;
  assign out_ch.word_number   = out_ev.word_number;
  assign out_ch.command_kind  = out_ev.command_kind;
  assign out_ch.command_bytes = out_ev.command_bytes;
  assign out_ch.last_result   = out_last;

endmodule

/* design/rrf_checker.sv */
// port-level checks on the framer, bound to the top level
module rrf_checker (
  input  logic      clk,
  input  logic      rst_n,
  rrf_in_if.sink    in_ch,
  rrf_out_if.source out_ch
);

  // a word offered but not taken stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid)
    else $error("output word dropped while stalled");

  // only payload events carry a byte or a first flag
  a_payload_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && (out_ch.event_kind != rrf_pkg::EV_BYTE) |->
      (out_ch.payload == 8'd0) && !out_ch.word_first)
    else $error("non-payload event carries payload");

  // command end and error carry no word number, only command end carries a count
  a_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && (out_ch.event_kind != rrf_pkg::EV_CMD_END) |->
      (out_ch.command_bytes == 16'd0) &&
      ((out_ch.event_kind == rrf_pkg::EV_BYTE) ||
       (out_ch.event_kind == rrf_pkg::EV_WORD_END) ||
       (out_ch.word_number == 10'd0)))
    else $error("event carries a field it should leave zero");

  // input is held off only while events are waiting to go out
  a_stall_has_output: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> out_ch.valid)
    else $error("input stalled with nothing offered");

  // nothing is offered right after reset
  a_reset_empty: assert property (@(posedge clk)
    $rose(rst_n) |-> !out_ch.valid)
    else $error("output valid right after reset");

endmodule

bind resp_request_framer_top rrf_checker u_rrf_checker (
  .clk    (clk),
  .rst_n  (rst_n),
  .in_ch  (in_ch),
  .out_ch (out_ch)
);
